// ===== hw/rtl/mcs_pkg.sv =====
package mcs_pkg;

  localparam int unsigned WindowLenDef = 10;
  localparam int unsigned WindowLenMax = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned SumW         = 20;
  localparam int unsigned QueueDepth   = 2;

  localparam logic [CfgIdxW-1:0] RegCalibEnable = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSmoothMode  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegXLow        = 3'd2;
  localparam logic [CfgIdxW-1:0] RegXHigh       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegYLow        = 3'd4;
  localparam logic [CfgIdxW-1:0] RegYHigh       = 3'd5;
  localparam logic [CfgIdxW-1:0] RegZLow        = 3'd6;
  localparam logic [CfgIdxW-1:0] RegZHigh       = 3'd7;

  localparam logic [1:0] ModeOff     = 2'd0;
  localparam logic [1:0] ModeAverage = 2'd1;
  localparam logic [1:0] ModeTrimmed = 2'd2;

  typedef struct packed {
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } sample_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
  } sample_out_t;

  // Work packet from the front (calibration) to the back (smoothing).
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] val_x;
    logic signed [15:0] val_y;
    logic signed [15:0] val_z;
  } work_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = -16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/magnetometer_calibrate_smooth.sv =====
// Three-axis magnetometer hard/soft-iron calibration and moving-average
// smoothing. Each transaction in carries one raw sample and yields exactly one
// transaction out. The front end subtracts (low+high)/2 per axis and scales by
// avg_halfspan/axis_halfspan through a shared bit-serial divider for each axis
// with a non-zero half-span (S_WAIT forms the product, S_MUL starts the
// divider, S_DIV waits for it); a zero half-span leaves the offset value
// unscaled. The front end takes a new transaction only once the last one has
// been pushed into the queue. A two-entry queue decouples it from the back end,
// which in average and trimmed modes updates the WINDOW_LEN-deep history ring
// and running sums as it takes a packet, then per axis scans the ring for min
// and max (trimmed mode) and divides by WINDOW_LEN (WINDOW_LEN-2 after trimming)
// through a registered reciprocal multiply. The back end takes a new packet only
// once its last result has been accepted, so an output stall holds it;
// throughput is set by the slower of the two ends. Registers should be written
// only while the block is idle; the ring and sums clear only on reset.
module magnetometer_calibrate_smooth #(
  parameter int unsigned WINDOW_LEN = mcs_pkg::WindowLenDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mcs_pkg::sample_in_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mcs_pkg::sample_out_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mcs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mcs_pkg::CfgDataW-1:0]   cfg_data_i
);
  import mcs_pkg::*;

  // Configuration registers
  logic               calib_enable_q;
  logic [1:0]         smooth_mode_q;
  logic signed [15:0] cal_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_enable_q <= 1'b0;
      smooth_mode_q  <= ModeOff;
      for (int i = 0; i < 6; i++) cal_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCalibEnable: calib_enable_q <= cfg_data_i[0];
        RegSmoothMode:  smooth_mode_q  <= cfg_data_i[1:0];
        RegXLow:        cal_q[0] <= cfg_data_i;
        RegXHigh:       cal_q[1] <= cfg_data_i;
        RegYLow:        cal_q[2] <= cfg_data_i;
        RegYHigh:       cal_q[3] <= cfg_data_i;
        RegZLow:        cal_q[4] <= cfg_data_i;
        RegZHigh:       cal_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic  q_push, q_full, q_pop, q_empty;
  work_t q_wdata, q_rdata;

  mcs_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .calib_enable_i(calib_enable_q),
    .smooth_mode_i (smooth_mode_q),
    .cal_i         (cal_q),
    .wr_valid_o    (q_push),
    .wr_ready_i    (!q_full),
    .wr_data_o     (q_wdata)
  );

  mcs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (q_push),
    .full_o (q_full),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (q_rdata)
  );

  mcs_back #(.WindowLen(WINDOW_LEN)) u_back (
    .clk_i, .rst_ni,
    .rd_empty_i (q_empty),
    .rd_pop_o   (q_pop),
    .rd_data_i  (q_rdata),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );
endmodule

// ===== hw/rtl/mcs_div.sv =====
// Signed restoring divider, truncation toward zero, one quotient bit per cycle.
module mcs_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic signed [19:0] den_i,
  output logic               done_o,
  output logic signed [47:0] quo_o
);
  import mcs_pkg::*;

  logic [47:0] rem_q, rem_d, quo_q, quo_d, num_q, num_d;
  logic [19:0] den_q, den_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [48:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; num_d = num_q; den_d = den_q;
    neg_d = neg_q; busy_d = busy_q; cnt_d = cnt_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      num_d  = num_i[47] ? 48'(-num_i) : num_i;
      den_d  = den_i[19] ? 20'(-den_i) : den_i;
      neg_d  = num_i[47] ^ den_i[19];
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd47;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[cnt_q]};
      if (trial >= {29'd0, den_q}) begin
        rem_d = 48'(trial - {29'd0, den_q});
        quo_d = quo_q | (48'd1 << cnt_q);
      end else begin
        rem_d = trial[47:0];
      end
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; num_q <= num_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? 48'(-quo_q) : quo_q;
endmodule

// ===== hw/rtl/mcs_front.sv =====
// Calibration: offset, scale by avg/half per axis through a shared divider.
module mcs_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcs_pkg::sample_in_t  in_data_i,
  input  logic                 calib_enable_i,
  input  logic [1:0]           smooth_mode_i,
  input  logic signed [15:0]   cal_i [6],
  output logic                 wr_valid_o,
  input  logic                 wr_ready_i,
  output mcs_pkg::work_t       wr_data_o
);
  import mcs_pkg::*;

  // ceil(2^17/3): exact floor(n/3) for n below 2^17
  localparam logic [16:0] Recip3 = 17'((2**17 + 2) / 3);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_WAIT, S_PUSH} state_e;

  state_e             state_q;
  logic [1:0]         axis_q;
  logic signed [15:0] val_q [3];
  logic signed [16:0] offs [3];
  logic signed [16:0] half [3];
  logic signed [18:0] hsum;
  logic [18:0]        hmag;
  logic [35:0]        hprod;
  logic signed [16:0] avg;
  logic signed [16:0] avg_q;
  logic signed [17:0] d_q;
  logic signed [47:0] prod_q;
  logic               div_start;
  logic               div_done;
  logic signed [47:0] div_quo;
  logic signed [17:0] hsel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      offs[i] = 17'((18'(cal_i[2*i]) + 18'(cal_i[2*i+1])) / 2);
      half[i] = 17'((18'(cal_i[2*i+1]) - 18'(cal_i[2*i])) / 2);
    end
    hsum = 19'(half[0]) + 19'(half[1]) + 19'(half[2]);
    // hsum/3 toward zero by reciprocal multiply on the magnitude
    hmag  = hsum[18] ? 19'(-hsum) : 19'(hsum);
    hprod = hmag * Recip3;
    avg   = hsum[18] ? -$signed(hprod[33:17]) : $signed(hprod[33:17]);
    hsel = 18'(half[axis_q]);
  end

  assign div_start = (state_q == S_MUL);

  mcs_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i  (prod_q),
    .den_i  (20'(hsel)),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      axis_q  <= '0;
      avg_q   <= '0;
    end else begin
      avg_q <= avg;
      case (state_q)
        S_IDLE: if (in_valid_i) begin
          val_q[0] <= in_data_i.raw_x;
          val_q[1] <= in_data_i.raw_y;
          val_q[2] <= in_data_i.raw_z;
          axis_q   <= '0;
          state_q  <= calib_enable_i ? S_WAIT : S_PUSH;
          d_q      <= 18'(in_data_i.raw_x) - 18'(offs[0]);
        end
        S_WAIT: begin
          if (half[axis_q] == '0) begin
            val_q[axis_q] <= sat16(48'(d_q));
            if (axis_q == 2'd2) state_q <= S_PUSH;
            else begin
              axis_q <= axis_q + 2'd1;
              d_q <= 18'(val_q[axis_q + 2'd1]) - 18'(offs[axis_q + 2'd1]);
            end
          end else begin
            prod_q  <= 48'(d_q * avg_q);
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_DIV;
        S_DIV: if (div_done) begin
          val_q[axis_q] <= sat16(div_quo);
          if (axis_q == 2'd2) state_q <= S_PUSH;
          else begin
            axis_q  <= axis_q + 2'd1;
            d_q     <= 18'(val_q[axis_q + 2'd1]) - 18'(offs[axis_q + 2'd1]);
            state_q <= S_WAIT;
          end
        end
        S_PUSH: if (wr_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign wr_valid_o = (state_q == S_PUSH);
  assign wr_data_o  = '{mode: smooth_mode_i, val_x: val_q[0], val_y: val_q[1],
                        val_z: val_q[2]};

  a_push_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("front reaccepted");
  a_push_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_valid_o && !wr_ready_i) |=> wr_valid_o) else $error("push dropped");
  a_div_only_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("stray divide");
endmodule

// ===== hw/rtl/mcs_queue.sv =====
// Small FIFO between calibration and smoothing.
module mcs_queue #(
  parameter int unsigned Depth = mcs_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  mcs_pkg::work_t data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output mcs_pkg::work_t data_o
);
  import mcs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t            mem_q [Depth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [PtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o)
        wp_q <= (wp_q == PtrW'(Depth-1)) ? '0 : wp_q + 1'b1;
      if (pop_i && !empty_o)
        rp_q <= (rp_q == PtrW'(Depth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && !empty_o);
    end
  end
endmodule

// ===== hw/rtl/mcs_back.sv =====
// Smoothing: ring update, min/max scan over cycles, divide by the window (less two when trimmed).
module mcs_back #(
  parameter int unsigned WindowLen = mcs_pkg::WindowLenDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rd_empty_i,
  output logic                  rd_pop_o,
  input  mcs_pkg::work_t        rd_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mcs_pkg::sample_out_t  out_data_o
);
  import mcs_pkg::*;

  localparam int unsigned IdxW    = $clog2(WindowLen);
  // Divide by the window through ceil(2^24/d); exact for magnitudes below 2^20.
  localparam int unsigned RecipSh = 24;
  localparam int unsigned ProdW   = SumW + RecipSh + 1;
  localparam logic [RecipSh:0] RecipAvg =
    (RecipSh+1)'(((64'd1 << RecipSh) + 64'(WindowLen) - 64'd1) / 64'(WindowLen));
  localparam logic [RecipSh:0] RecipTrim =
    (RecipSh+1)'(((64'd1 << RecipSh) + 64'(WindowLen) - 64'd3) / 64'(WindowLen - 2));

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_START, S_DIV, S_OUT} state_e;

  state_e             state_q;
  logic signed [15:0] ring_q [WindowLen][3];
  logic signed [SumW-1:0] sum_q [3];
  logic [IdxW-1:0]    slot_q, scan_q;
  logic [1:0]         axis_q;
  logic               trim_q;
  logic signed [15:0] val_q [3];
  logic signed [15:0] mx_q, mn_q, h;
  logic signed [SumW:0]   num;
  logic [SumW-1:0]        num_mag;
  logic [ProdW-1:0]       prod_q;
  logic                   neg_q;
  logic [SumW:0]          quo_mag;
  logic signed [SumW+1:0] quo;

  assign h = ring_q[scan_q][axis_q];
  assign num = trim_q ? (SumW+1)'(sum_q[axis_q] - SumW'(mx_q) - SumW'(mn_q))
                      : (SumW+1)'(sum_q[axis_q]);
  assign num_mag = num[SumW] ? SumW'(-num) : SumW'(num);
  assign quo_mag = prod_q[ProdW-1:RecipSh];
  assign quo     = neg_q ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      scan_q  <= '0;
      axis_q  <= '0;
      trim_q  <= 1'b0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
      for (int j = 0; j < WindowLen; j++)
        for (int i = 0; i < 3; i++) ring_q[j][i] <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (!rd_empty_i) begin
          val_q[0] <= rd_data_i.val_x;
          val_q[1] <= rd_data_i.val_y;
          val_q[2] <= rd_data_i.val_z;
          if (rd_data_i.mode == ModeAverage || rd_data_i.mode == ModeTrimmed) begin
            sum_q[0] <= sum_q[0] - SumW'(ring_q[slot_q][0]) + SumW'(rd_data_i.val_x);
            sum_q[1] <= sum_q[1] - SumW'(ring_q[slot_q][1]) + SumW'(rd_data_i.val_y);
            sum_q[2] <= sum_q[2] - SumW'(ring_q[slot_q][2]) + SumW'(rd_data_i.val_z);
            ring_q[slot_q][0] <= rd_data_i.val_x;
            ring_q[slot_q][1] <= rd_data_i.val_y;
            ring_q[slot_q][2] <= rd_data_i.val_z;
            slot_q <= (slot_q == IdxW'(WindowLen-1)) ? '0 : slot_q + 1'b1;
            trim_q <= (rd_data_i.mode == ModeTrimmed);
            axis_q <= '0;
            scan_q <= '0;
            mx_q   <= -16'sh8000;
            mn_q   <= 16'sh7fff;
            state_q <= (rd_data_i.mode == ModeTrimmed) ? S_SCAN : S_START;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_SCAN: begin
          if (h > mx_q) mx_q <= h;
          if (h < mn_q) mn_q <= h;
          if (scan_q == IdxW'(WindowLen-1)) state_q <= S_START;
          else scan_q <= scan_q + 1'b1;
        end
        S_START: begin
          prod_q  <= num_mag * (trim_q ? RecipTrim : RecipAvg);
          neg_q   <= num[SumW];
          state_q <= S_DIV;
        end
        S_DIV: begin
          val_q[axis_q] <= sat16(48'(quo));
          if (axis_q == 2'd2) state_q <= S_OUT;
          else begin
            axis_q  <= axis_q + 2'd1;
            scan_q  <= '0;
            mx_q    <= -16'sh8000;
            mn_q    <= 16'sh7fff;
            state_q <= trim_q ? S_SCAN : S_START;
          end
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rd_pop_o    = (state_q == S_IDLE) && !rd_empty_i;
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = '{out_x: val_q[0], out_y: val_q[1], out_z: val_q[2]};

  a_pop_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pop_o |=> !rd_pop_o) else $error("double pop");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result dropped");
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q <= IdxW'(WindowLen-1)) else $error("slot out of window");
endmodule

// ===== verif/tb.sv =====
module tb;
  import mcs_pkg::*;

  localparam int unsigned WindowLen = WindowLenDef;
  // Cycles without any transaction before the run is declared hung.
  localparam int unsigned HangLimit = 20000;
  // Drain time after the last result.
  localparam int unsigned DrainCycles = 400;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  sample_in_t          in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  sample_out_t         out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  magnetometer_calibrate_smooth #(.WINDOW_LEN(WindowLen)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow of the register file and the smoothing window.
  // ---------------------------------------------------------------------------
  logic               calib_on;
  logic [1:0]         smooth_sel;
  logic signed [15:0] axis_low [3];
  logic signed [15:0] axis_high[3];
  logic signed [15:0] window_ring[WindowLen][3];
  longint             window_sum[3];
  int                 ring_slot;

  sample_out_t corrected_samples[$];   // expected outputs, oldest first
  int          mismatches;
  int          samples_sent;
  int          samples_checked;
  bit          jitter_on;              // random idling on both sides
  int          long_hold_req;          // receiver hold-off, picked up by its process
  int          quiet_cycles;

  function automatic longint clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Calibrate then smooth one sample; advances the shadow window in average and trimmed modes.
  // Integer division in SV truncates toward zero, as the block does.
  function automatic sample_out_t correct_sample(input sample_in_t s);
    longint      v[3];
    longint      offs[3];
    longint      half[3];
    longint      avg_half;
    longint      peak;
    longint      trough;
    int          slot;
    sample_out_t r;
    v[0] = s.raw_x;
    v[1] = s.raw_y;
    v[2] = s.raw_z;
    for (int a = 0; a < 3; a++) begin
      offs[a] = (longint'(axis_low[a]) + longint'(axis_high[a])) / 2;
      half[a] = (longint'(axis_high[a]) - longint'(axis_low[a])) / 2;
    end
    avg_half = (half[0] + half[1] + half[2]) / 3;
    if (calib_on) begin
      for (int a = 0; a < 3; a++) begin
        // zero half-span: unity scale
        if (half[a] == 0) v[a] = clip16(v[a] - offs[a]);
        else v[a] = clip16(((v[a] - offs[a]) * avg_half) / half[a]);
      end
    end
    if (smooth_sel == ModeAverage || smooth_sel == ModeTrimmed) begin
      slot = (ring_slot >= WindowLen) ? 0 : ring_slot;
      for (int a = 0; a < 3; a++) begin
        window_sum[a] = window_sum[a] - window_ring[slot][a] + v[a];
        window_ring[slot][a] = v[a];
        if (smooth_sel == ModeTrimmed) begin
          peak = window_ring[0][a];
          trough = window_ring[0][a];
          for (int j = 1; j < WindowLen; j++) begin
            if (window_ring[j][a] > peak) peak = window_ring[j][a];
            if (window_ring[j][a] < trough) trough = window_ring[j][a];
          end
          v[a] = clip16((window_sum[a] - peak - trough) / longint'(WindowLen - 2));
        end else begin
          v[a] = clip16(window_sum[a] / longint'(WindowLen));
        end
      end
      ring_slot = (slot + 1 >= WindowLen) ? 0 : slot + 1;
    end
    r.out_x = v[0][15:0];
    r.out_y = v[1][15:0];
    r.out_z = v[2][15:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Valid is left high after acceptance so back-to-back calls
  // stream without a bubble; release_input drops it at phase ends.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    sample_in_t s;
    int         gap;
    s.raw_x = x;
    s.raw_y = y;
    s.raw_z = z;
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    do @(posedge clk_i); while (!in_ready_o);
    corrected_samples.push_back(correct_sample(s));
    samples_sent++;
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  // Pause the sender until every outstanding transaction has come back.
  task automatic drain_block();
    release_input();
    @(posedge clk_i);
    while (corrected_samples.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Writes all eight registers, one per cycle. Unused data bits carry noise.
  task automatic write_config(input logic c, input logic [1:0] m,
                              input logic signed [15:0] xl, input logic signed [15:0] xh,
                              input logic signed [15:0] yl, input logic signed [15:0] yh,
                              input logic signed [15:0] zl, input logic signed [15:0] zh);
    logic [CfgIdxW-1:0]  idx[8];
    logic [CfgDataW-1:0] dat[8];
    idx = '{RegCalibEnable, RegSmoothMode, RegXLow, RegXHigh, RegYLow, RegYHigh,
            RegZLow, RegZHigh};
    dat = '{{15'($urandom), c}, {14'($urandom), m}, xl, xh, yl, yh, zl, zh};
    for (int k = 0; k < 8; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= dat[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    calib_on     = c;
    smooth_sel   = m;
    axis_low[0]  = xl;
    axis_high[0] = xh;
    axis_low[1]  = yl;
    axis_high[1] = yh;
    axis_low[2]  = zl;
    axis_high[2] = zh;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random back-pressure bursts plus an optional long hold-off.
  // Exactly one assignment to out_ready_i per edge.
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (long_hold_req > 0) begin
        out_ready_i <= 1'b0;
        stall_left = long_hold_req - 1;
        long_hold_req = 0;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    $display("ERROR: %s expected %0d got %0d (result %0d)", what, $signed(want),
             $signed(got), samples_checked);
    mismatches++;
  endtask

  // Result checker: every output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    sample_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (corrected_samples.size() == 0) begin
        $display("ERROR: unexpected output transaction");
        mismatches++;
      end else begin
        want = corrected_samples.pop_front();
        if (out_data_o.out_x !== want.out_x) report_mismatch("out_x", want.out_x, out_data_o.out_x);
        if (out_data_o.out_y !== want.out_y) report_mismatch("out_y", want.out_y, out_data_o.out_y);
        if (out_data_o.out_z !== want.out_z) report_mismatch("out_z", want.out_z, out_data_o.out_z);
      end
      samples_checked++;
    end
  end

  // Hang detector: counts cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= HangLimit) begin
      $display("Timeout: no transaction for %0d cycles", HangLimit);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return -16'sh8000;
      2, 3, 4: return 16'($signed($urandom_range(0, 1200)) - 600);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] pick_extreme(input bit upper);
    case ($urandom_range(0, 5))
      0:       return upper ? 16'sh7fff : -16'sh8000;
      1:       return 16'($urandom);   // may reverse or zero the span
      2:       return 16'($signed($urandom_range(0, 40)) - 20);
      default: return upper ? 16'($signed($urandom_range(50, 900)))
                            : 16'(-$signed($urandom_range(50, 900)));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_passthrough();
    // reset config: no calibration, no smoothing
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7fff, -16'sh8000, 16'sh7fff);
    send_sample(-16'sh8000, 16'sh7fff, -16'sh8000);
    send_sample(16'sh5555, 16'shaaaa, 16'sh5555);
    send_sample(16'shaaaa, 16'sh5555, -16'sh0001);
    drain_block();
  endtask

  task automatic test_calibration();
    // ordinary spans, zero span on z (unity scale)
    write_config(1'b1, ModeOff, -400, 600, -300, 300, 50, 50);
    send_sample(100, -100, 77);
    send_sample(16'sh7fff, -16'sh8000, -16'sh8000);
    drain_block();
    // full-range x with tiny y span: scaled values saturate
    write_config(1'b1, ModeOff, -16'sh8000, 16'sh7fff, -2, 2, -16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh7fff, -16'sh8000);
    send_sample(-16'sh8000, -16'sh8000, 0);
    drain_block();
    // reversed extremes on y and z: negative half-span flips the scale
    write_config(1'b1, ModeOff, -100, 100, 500, -500, 16'sh7fff, -16'sh8000);
    send_sample(1234, 321, -9999);
    send_sample(-16'sh8000, 16'sh7fff, 16'sh7fff);
    drain_block();
  endtask

  task automatic test_smoothing();
    write_config(1'b0, ModeAverage, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < 4; k++) send_sample(16'sh7fff, -16'sh8000, 16'(k * 1000));
    drain_block();
    // trimmed on a partly filled window, then unused mode 3 acts as off
    write_config(1'b1, ModeTrimmed, -1000, 1000, -800, 1200, -16'sh8000, 16'sh7fff);
    for (int k = 0; k < 4; k++) send_sample(pick_raw(), pick_raw(), pick_raw());
    drain_block();
    write_config(1'b0, 2'd3, 0, 0, 0, 0, 0, 0);
    send_sample(42, -42, 16'sh7fff);
    drain_block();
  endtask

  // Receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    write_config(1'b1, ModeAverage, -500, 700, -600, 400, -300, 900);
    long_hold_req = 1500;
    for (int k = 0; k < 12; k++) send_sample(pick_raw(), pick_raw(), pick_raw());
    drain_block();
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [1:0] m;
    for (int p = 0; p < phases; p++) begin
      // first phases pin the extremes of the register ranges
      if (p == 0) begin
        write_config(1'b1, ModeTrimmed, -16'sh8000, 16'sh7fff, -16'sh8000, 16'sh7fff,
                     16'sh7fff, -16'sh8000);
      end else if (p == 1) begin
        write_config(1'b0, ModeOff, 16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 0, 0);
      end else begin
        m = 2'($urandom_range(0, 3));
        write_config(1'($urandom), m, pick_extreme(0), pick_extreme(1), pick_extreme(0),
                     pick_extreme(1), pick_extreme(0), pick_extreme(1));
      end
      // last phase runs at full rate on both sides
      jitter_on = (p != phases - 1);
      for (int k = 0; k < per_phase; k++) send_sample(pick_raw(), pick_raw(), pick_raw());
      drain_block();
    end
  endtask

  initial begin
    mismatches      = 0;
    samples_sent    = 0;
    samples_checked = 0;
    quiet_cycles    = 0;
    long_hold_req   = 0;
    jitter_on       = 1'b1;
    calib_on        = 1'b0;
    smooth_sel      = ModeOff;
    ring_slot       = 0;
    for (int a = 0; a < 3; a++) begin
      axis_low[a]   = '0;
      axis_high[a]  = '0;
      window_sum[a] = 0;
      for (int j = 0; j < WindowLen; j++) window_ring[j][a] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_calibration();
    test_smoothing();
    test_backpressure();
    test_random(10, 127);

    while (corrected_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d samples across calibration on/off and all smoothing modes,", samples_sent);
    $display("%0d output transactions checked under random back-pressure.", samples_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mcs_pkg.sv
hw/rtl/mcs_div.sv
hw/rtl/mcs_front.sv
hw/rtl/mcs_queue.sv
hw/rtl/mcs_back.sv
hw/rtl/magnetometer_calibrate_smooth.sv
verif/tb.sv
